// File: rtl/core/rfac_pkg.sv
// shared constants, types and character helpers for the rfid ascii frame checker
package rfac_pkg;

   // framing codes on the serial line
   localparam logic [7:0] STX_CODE = 8'h02;
   localparam logic [7:0] ETX_CODE = 8'h03;

   // ascii codes used by the hex digit mapping
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_F = 8'h46;
   localparam logic [7:0] HEX_TEN = 8'd10;

   // width of the character position on the result channel
   localparam int unsigned INDEX_W = 4;

   // end of frame status handed from the frame store to the emitter
   typedef struct packed {
      logic done;
      logic ok;
   } frame_done_type;

   // uppercase hex digit to its value, any other character keeps its code
   function automatic logic [7:0] char_to_nibble(input logic [7:0] c);
      logic [7:0] res;
      res = c;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         res = c - CHAR_0;
      end else if (c >= CHAR_A && c <= CHAR_F) begin
         res = c - CHAR_A + HEX_TEN;
      end
      return res;
   endfunction

   // two characters to one byte, first character is the low nibble
   function automatic logic [7:0] pair_value(input logic [7:0] lo_c, input logic [7:0] hi_c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = char_to_nibble(lo_c);
      hi = char_to_nibble(hi_c);
      return lo | {hi[3:0], 4'h0};
   endfunction

endpackage

// File: rtl/core/rfac_frame_store.sv
// frame tracking, character store and checksum check at end of frame
module rfac_frame_store #(
   parameter int unsigned FRAME_CHARS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rx_vld,
   input  logic [7:0]                  rx_byte,
   input  logic                        emit_busy,
   output logic                        consume,
   output rfac_pkg::frame_done_type    frame_done,
   output logic [FRAME_CHARS-1:0][7:0] frame_chars
);

   localparam int unsigned PAIR_COUNT = FRAME_CHARS / 2;
   localparam int unsigned CNT_W      = $clog2(FRAME_CHARS + 1);
   localparam int unsigned WIDX_W     = $clog2(FRAME_CHARS);

   logic                        in_frame_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [FRAME_CHARS-1:0][7:0] chars_ff;
   logic                        in_frame_in;
   logic [CNT_W-1:0]            cnt_in;
   logic [FRAME_CHARS-1:0][7:0] chars_in;
   logic [CNT_W-1:0]            cnt_inc;
   logic                        is_stx;
   logic                        is_term;
   logic                        ends;
   logic [7:0]                  sum;
   logic                        ok;

   assign is_stx  = (rx_byte == rfac_pkg::STX_CODE);
   assign is_term = is_stx || (rx_byte == rfac_pkg::ETX_CODE);
   assign cnt_inc = cnt_ff + CNT_W'(1);

   // this item closes the frame
   assign ends = in_frame_ff && (is_term || (cnt_inc == CNT_W'(FRAME_CHARS)));

   // a frame end waits until the emitter has drained the previous burst
   assign consume = rx_vld && !(ends && emit_busy);

   // next state of the frame tracker and store
   always_comb begin
      in_frame_in = in_frame_ff;
      cnt_in      = cnt_ff;
      chars_in    = chars_ff;
      if (!in_frame_ff) begin
         if (is_stx) begin
            in_frame_in = 1'b1;
            cnt_in      = '0;
            chars_in    = '0;
         end
      end else if (is_term) begin
         in_frame_in = 1'b0;
         cnt_in      = '0;
      end else begin
         chars_in[cnt_ff[WIDX_W-1:0]] = rx_byte;
         if (ends) begin
            in_frame_in = 1'b0;
            cnt_in      = '0;
         end else begin
            cnt_in = cnt_inc;
         end
      end
   end

   // checksum over the id pairs against the final pair, with a nonzero first character
   always_comb begin
      sum = '0;
      for (int p = 0; p < PAIR_COUNT - 1; p++) begin
         sum = sum ^ rfac_pkg::pair_value(chars_in[2*p], chars_in[2*p+1]);
      end
      ok = (chars_in[0] != 8'h00) &&
           (rfac_pkg::pair_value(chars_in[2*(PAIR_COUNT-1)], chars_in[2*(PAIR_COUNT-1)+1]) == sum);
   end

   assign frame_done.done = consume && ends;
   assign frame_done.ok   = ok;
   assign frame_chars     = chars_in;

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         cnt_ff      <= '0;
      end else if (consume) begin
         in_frame_ff <= in_frame_in;
         cnt_ff      <= cnt_in;
      end
   end

   // character store, cleared by the frame start
   always_ff @(posedge clock) begin
      if (consume) begin
         chars_ff <= chars_in;
      end
   end

endmodule

// File: rtl/core/rfac_burst_emit.sv
// holds a finished frame, sends id chars one per cycle while rsp_ready
module rfac_burst_emit #(
   parameter int unsigned ID_CHARS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rfac_pkg::frame_done_type       frame_done,
   input  logic [ID_CHARS-1:0][7:0]       id_chars,
   output logic                           busy,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_valid_res,
   output logic [7:0]                     rsp_tag_char,
   output logic [rfac_pkg::INDEX_W-1:0]   rsp_char_index,
   output logic                           rsp_last
);

   localparam int unsigned IDX_W = $clog2(ID_CHARS);

   logic                     busy_ff;
   logic                     ok_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [ID_CHARS-1:0][7:0] buf_ff;
   logic                     at_end;

   assign at_end = !ok_ff || (idx_ff == IDX_W'(ID_CHARS - 1));

   // result fields from the held frame
   assign busy           = busy_ff;
   assign rsp_valid      = busy_ff;
   assign rsp_valid_res  = ok_ff;
   assign rsp_tag_char   = ok_ff ? buf_ff[idx_ff] : 8'h00;
   assign rsp_char_index = ok_ff ? rfac_pkg::INDEX_W'(idx_ff) : '0;
   assign rsp_last       = at_end;

   // burst control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (!busy_ff) begin
         if (frame_done.done) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end
      end else if (rsp_ready) begin
         if (at_end) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   // snapshot of the frame
   always_ff @(posedge clock) begin
      if (!busy_ff && frame_done.done) begin
         ok_ff  <= frame_done.ok;
         buf_ff <= id_chars;
      end
   end

endmodule

// File: rtl/core/rfid_ascii_frame_checker_top.sv
// top level of the rfid ascii frame checker: input register, frame store, burst emitter
// a frame-ending item passes the input register, then sets the emitter's busy register, which raises its first result
// throughput: one byte per cycle; a frame end waits while the previous burst drains
// a burst is ID_CHARS results (one per cycle while rsp_ready is high) or a single failed result
// reset: synchronous, returns to idle with no frame open and no burst pending
module rfid_ascii_frame_checker_top #(
   parameter int unsigned FRAME_CHARS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_valid_res,
   output logic [7:0]                   rsp_tag_char,
   output logic [rfac_pkg::INDEX_W-1:0] rsp_char_index,
   output logic                         rsp_last
);

   localparam int unsigned PAIR_COUNT = FRAME_CHARS / 2;
   localparam int unsigned ID_CHARS   = 2 * PAIR_COUNT - 2;

   logic                        rx_vld_ff;
   logic [7:0]                  rx_ff;
   logic                        consume;
   logic                        emit_busy;
   rfac_pkg::frame_done_type    frame_done;
   logic [FRAME_CHARS-1:0][7:0] frame_chars;

   assign req_ready = !rx_vld_ff || consume;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_vld_ff <= 1'b0;
      end else if (req_ready) begin
         rx_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         rx_ff <= req_rx_byte;
      end
   end

   rfac_frame_store #(
      .FRAME_CHARS(FRAME_CHARS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rx_vld     (rx_vld_ff),
      .rx_byte    (rx_ff),
      .emit_busy  (emit_busy),
      .consume    (consume),
      .frame_done (frame_done),
      .frame_chars(frame_chars)
   );

   rfac_burst_emit #(
      .ID_CHARS(ID_CHARS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .frame_done    (frame_done),
      .id_chars      (frame_chars[ID_CHARS-1:0]),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_tag_char  (rsp_tag_char),
      .rsp_char_index(rsp_char_index),
      .rsp_last      (rsp_last)
   );

   // the last item of a burst leaves the channel empty
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result channel still valid after last item");

   // a burst that is not finished carries on with valid id characters
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_valid_res)
      else $error("burst broke off before its last item");

   // a failed frame gives one zeroed item
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_last && (rsp_tag_char == 8'h00) && (rsp_char_index == '0))
      else $error("failed frame item not zeroed or not last");

   // the input side only stalls on a held byte while the emitter is busy
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rx_vld_ff && emit_busy)
      else $error("input stalled with no byte held");

endmodule

// File: tb/tag_burst_check.sv
`timescale 1ns / 100ps
// predicts the tag bursts of the frame checker from accepted bytes and compares every result
module tag_burst_check #(
   parameter int unsigned FRAME_CHARS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_valid_res,
   input  logic [7:0]                   rsp_tag_char,
   input  logic [rfac_pkg::INDEX_W-1:0] rsp_char_index,
   input  logic                         rsp_last,
   output int unsigned                  mismatches,
   output int unsigned                  tag_chars_pending,
   output int unsigned                  results_seen,
   output int unsigned                  id_chars_seen,
   output int unsigned                  rejects_seen
);

   localparam int unsigned PAIRS  = FRAME_CHARS / 2;
   localparam int unsigned ID_LEN = 2 * PAIRS - 2;

   typedef struct packed {
      logic                         valid_res;
      logic [7:0]                   tag_char;
      logic [rfac_pkg::INDEX_W-1:0] char_index;
      logic                         is_last;
   } tag_result_type;

   // expected results in order, plus the predicted frame store
   tag_result_type expected_tags[$];
   logic           frame_open;
   int unsigned    slots_filled;
   logic [7:0]     frame_slots [FRAME_CHARS];

   // hex digit to value, anything else passes through unchanged
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      if (c >= rfac_pkg::CHAR_0 && c <= rfac_pkg::CHAR_9) return c - rfac_pkg::CHAR_0;
      if (c >= rfac_pkg::CHAR_A && c <= rfac_pkg::CHAR_F) return c - rfac_pkg::CHAR_A + 8'd10;
      return c;
   endfunction

   // first char is the low nibble, result cut to a byte
   function automatic logic [7:0] byte_of_pair(input logic [7:0] lo_c, input logic [7:0] hi_c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = digit_value(lo_c);
      hi = digit_value(hi_c);
      return lo | (hi << 4);
   endfunction

   // checksum test and burst generation at the end of a frame
   task automatic close_frame();
      logic [7:0]     xsum;
      logic           good;
      tag_result_type r;
      xsum = 8'h00;
      for (int p = 0; p + 1 < PAIRS; p++) begin
         xsum ^= byte_of_pair(frame_slots[2*p], frame_slots[2*p+1]);
      end
      good = (frame_slots[0] != 8'h00) &&
             (byte_of_pair(frame_slots[2*PAIRS-2], frame_slots[2*PAIRS-1]) == xsum);
      frame_open   = 1'b0;
      slots_filled = 0;
      if (!good || ID_LEN == 0) begin
         r.valid_res  = 1'b0;
         r.tag_char   = 8'h00;
         r.char_index = '0;
         r.is_last    = 1'b1;
         expected_tags.push_back(r);
      end else begin
         for (int k = 0; k < ID_LEN; k++) begin
            r.valid_res  = 1'b1;
            r.tag_char   = frame_slots[k];
            r.char_index = k[rfac_pkg::INDEX_W-1:0];
            r.is_last    = (k == ID_LEN - 1);
            expected_tags.push_back(r);
         end
      end
   endtask

   // one accepted serial byte
   task automatic take_rx_byte(input logic [7:0] b);
      if (!frame_open) begin
         if (b == rfac_pkg::STX_CODE) begin
            frame_open   = 1'b1;
            slots_filled = 0;
            foreach (frame_slots[i]) frame_slots[i] = 8'h00;
         end
      end else if (b == rfac_pkg::STX_CODE || b == rfac_pkg::ETX_CODE) begin
         close_frame();
      end else begin
         if (slots_filled < FRAME_CHARS) begin
            frame_slots[slots_filled] = b;
            slots_filled++;
         end
         if (slots_filled >= FRAME_CHARS) close_frame();
      end
   endtask

   // results first: nothing accepted at this edge can already have a result
   always @(posedge clock) begin : watch
      tag_result_type want;
      tag_result_type got;
      if (reset) begin
         frame_open   = 1'b0;
         slots_filled = 0;
         foreach (frame_slots[i]) frame_slots[i] = 8'h00;
         expected_tags.delete();
         mismatches    = 0;
         results_seen  = 0;
         id_chars_seen = 0;
         rejects_seen  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.valid_res  = rsp_valid_res;
            got.tag_char   = rsp_tag_char;
            got.char_index = rsp_char_index;
            got.is_last    = rsp_last;
            results_seen++;
            if (rsp_valid_res) id_chars_seen++;
            else rejects_seen++;
            if (expected_tags.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: unexpected item valid_res=%0b tag_char=%02h",
                            " char_index=%0d last=%0b"},
                           $realtime, got.valid_res, got.tag_char, got.char_index,
                           got.is_last);
            end else begin
               want = expected_tags.pop_front();
               if (want != got) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch valid_res %0b/%0b tag_char %02h/%02h",
                               " index %0d/%0d last %0b/%0b (exp/got)"},
                              $realtime, want.valid_res, got.valid_res, want.tag_char,
                              got.tag_char, want.char_index, got.char_index,
                              want.is_last, got.is_last);
               end
            end
         end
         if (req_valid && req_ready) take_rx_byte(req_rx_byte);
      end
      tag_chars_pending = expected_tags.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench top: serial byte stimulus, result stalls, watchdog and verdict
module tb;

   localparam int unsigned FRAME_CHARS  = 12;
   localparam int unsigned ID_PAIRS     = FRAME_CHARS / 2 - 1;
   localparam int unsigned TARGET_BYTES = 150;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam logic [7:0]  CR_CODE      = 8'h0D;
   localparam logic [7:0]  LF_CODE      = 8'h0A;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [7:0]                   req_rx_byte;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_valid_res;
   logic [7:0]                   rsp_tag_char;
   logic [rfac_pkg::INDEX_W-1:0] rsp_char_index;
   logic                         rsp_last;

   logic        gaps_on;
   int unsigned bytes_sent;
   int unsigned frames_sent;
   int unsigned quiet_cycles;
   int unsigned mismatches;
   int unsigned tag_chars_pending;
   int unsigned results_seen;
   int unsigned id_chars_seen;
   int unsigned rejects_seen;

   rfid_ascii_frame_checker_top #(.FRAME_CHARS(FRAME_CHARS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_tag_char   (rsp_tag_char),
      .rsp_char_index (rsp_char_index),
      .rsp_last       (rsp_last)
   );

   tag_burst_check #(.FRAME_CHARS(FRAME_CHARS)) tag_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_tag_char      (rsp_tag_char),
      .rsp_char_index    (rsp_char_index),
      .rsp_last          (rsp_last),
      .mismatches        (mismatches),
      .tag_chars_pending (tag_chars_pending),
      .results_seen      (results_seen),
      .id_chars_seen     (id_chars_seen),
      .rejects_seen      (rejects_seen)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("FAIL rfid_ascii_frame_checker_top");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return rfac_pkg::CHAR_0 + n;
      return rfac_pkg::CHAR_A + (n - 4'd10);
   endfunction

   // any byte that does not end a frame
   function automatic logic [7:0] payload_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == rfac_pkg::STX_CODE || v == rfac_pkg::ETX_CODE);
      return v;
   endfunction

   // one item on the byte channel, with an optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b, input bit counted);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (!req_ready);
      if (counted) bytes_sent++;
   endtask

   // reader style frame of hex digits, checksum right or deliberately broken
   task automatic send_tag_frame(input bit corrupt);
      logic [7:0] id_byte;
      logic [7:0] xsum;
      xsum = 8'h00;
      send_byte(rfac_pkg::STX_CODE, 1);
      for (int p = 0; p < ID_PAIRS; p++) begin
         id_byte = 8'($urandom_range(0, 255));
         xsum ^= id_byte;
         send_byte(hex_char(id_byte[3:0]), 1);
         send_byte(hex_char(id_byte[7:4]), 1);
      end
      if (corrupt) xsum ^= 8'(1 << $urandom_range(0, 7));
      send_byte(hex_char(xsum[3:0]), 1);
      send_byte(hex_char(xsum[7:4]), 1);
      // cr lf etx trailer lands while idle and is dropped
      if ($urandom_range(0, 1) == 1) begin
         send_byte(CR_CODE, 0);
         send_byte(LF_CODE, 0);
         send_byte(rfac_pkg::ETX_CODE, 0);
      end
      frames_sent++;
   endtask

   // raw id pairs sent twice cancel in the xor, so arbitrary chars can still pass
   task automatic send_twin_frame();
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] xsum;
      int         p;
      xsum = 8'h00;
      p    = 0;
      send_byte(rfac_pkg::STX_CODE, 1);
      while (p + 1 < ID_PAIRS) begin
         a = payload_byte();
         b = payload_byte();
         repeat (2) begin
            send_byte(a, 1);
            send_byte(b, 1);
         end
         p += 2;
      end
      if (p < ID_PAIRS) begin
         xsum = 8'($urandom_range(0, 255));
         send_byte(hex_char(xsum[3:0]), 1);
         send_byte(hex_char(xsum[7:4]), 1);
      end
      send_byte(hex_char(xsum[3:0]), 1);
      send_byte(hex_char(xsum[7:4]), 1);
      frames_sent++;
   endtask

   // random content, possibly cut short by stx or etx
   task automatic send_raw_frame();
      int unsigned n;
      n = $urandom_range(0, FRAME_CHARS);
      send_byte(rfac_pkg::STX_CODE, 1);
      repeat (n) send_byte(payload_byte(), 1);
      if (n < FRAME_CHARS)
         send_byte($urandom_range(0, 1) ? rfac_pkg::STX_CODE : rfac_pkg::ETX_CODE, 1);
      frames_sent++;
   endtask

   // unstructured bytes, framing codes included, then etx to get back to idle
   task automatic send_junk();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 3) == 0)
            send_byte($urandom_range(0, 1) ? rfac_pkg::STX_CODE : rfac_pkg::ETX_CODE, 1);
         else send_byte(8'($urandom_range(0, 255)), 1);
      end
      send_byte(rfac_pkg::ETX_CODE, 1);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      gaps_on     = 1'b1;
      bytes_sent  = 0;
      frames_sent = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // idle bytes at the extremes are dropped
      send_byte(8'h00, 1);
      send_byte(8'hFF, 1);
      send_byte(rfac_pkg::ETX_CODE, 1);
      // empty frame closed by etx, then by a second stx
      send_byte(rfac_pkg::STX_CODE, 1);
      send_byte(rfac_pkg::ETX_CODE, 1);
      send_byte(rfac_pkg::STX_CODE, 1);
      send_byte(rfac_pkg::STX_CODE, 1);
      // zero first character
      send_byte(rfac_pkg::STX_CODE, 1);
      send_byte(8'h00, 1);
      send_byte(rfac_pkg::ETX_CODE, 1);
      // one clean frame
      send_tag_frame(1'b0);
      frames_sent += 3;

      // random part, mostly well-formed frames
      while (bytes_sent < TARGET_BYTES) begin
         int unsigned pick;
         if (bytes_sent > TARGET_BYTES * 3 / 4) gaps_on = 1'b0;
         pick = $urandom_range(0, 19);
         if (pick <= 10) send_tag_frame(1'b0);
         else if (pick <= 12) send_tag_frame(1'b1);
         else if (pick <= 14) send_twin_frame();
         else if (pick <= 17) send_raw_frame();
         else send_junk();
      end
      gaps_on = 1'b0;
      @(negedge clock);
      req_valid = 1'b0;

      while (tag_chars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in about %0d frames; checked %0d results", bytes_sent,
               frames_sent, results_seen);
      $display("tag characters %0d, rejected frames %0d, mismatches %0d", id_chars_seen,
               rejects_seen, mismatches);
      if (mismatches == 0 && tag_chars_pending == 0) begin
         $display("PASS rfid_ascii_frame_checker_top");
      end else begin
         if (tag_chars_pending != 0) $display("%0d results never arrived", tag_chars_pending);
         $display("FAIL rfid_ascii_frame_checker_top");
      end
      $finish;
   end

endmodule

// File: rfid_ascii_frame_checker_top.f
rtl/core/rfac_pkg.sv
rtl/core/rfac_frame_store.sv
rtl/core/rfac_burst_emit.sv
rtl/core/rfid_ascii_frame_checker_top.sv
tb/tag_burst_check.sv
tb/tb.sv
